### hdl/impe_pkg.sv
// Shared types, constants and helpers for the image marker payload extractor.
// No dependencies; the top, front, queue and back files refer to this package by scope.
package impe_pkg;

    // Frame size default and the floor of the delay line depth
    localparam int MIN_FRAME_BYTES_DEF = 16;
    localparam int DEPTH_FLOOR         = 16;

    // Width of the byte count fields in a command (covers depths up to 127)
    localparam int CNT_W = 7;

    // Command queue between front and back, must be a power of two
    localparam int QUEUE_DEPTH = 4;

    // Marker geometry: the running scan looks at tap 7, length bytes sit above the marker
    localparam int SCAN_TAP  = 7;
    localparam int JPEG_LEN  = 3;
    localparam int LEN_BYTES = 4;
    localparam int WIN_TOP   = SCAN_TAP + LEN_BYTES;

    localparam logic [7:0] JPEG_B0 = 8'hFF;
    localparam logic [7:0] JPEG_B1 = 8'hD8;
    localparam logic [7:0] PNG_B0  = 8'h89;
    localparam logic [7:0] PNG_B1  = 8'h50;
    localparam logic [7:0] PNG_B2  = 8'h4E;
    localparam logic [7:0] PNG_B3  = 8'h47;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_SMALL   = 2'd2,
        KIND_NOMARK  = 2'd3
    } t_kind;

    // One command per accepted byte: the byte itself, a run of payload bytes to
    // replay from the ring (count, starting back bytes behind this one), and an
    // optional closing status item.
    typedef struct packed {
        logic [7:0]       data;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] back;
        logic             has_status;
        t_kind            kind;
    } t_cmd;

    function automatic int depth_of(input int min_bytes);
        return (min_bytes > DEPTH_FLOOR) ? min_bytes : DEPTH_FLOOR;
    endfunction

endpackage

### hdl/impe_in_if.sv
// Input channel of the extractor: one frame byte with its end flag per transaction.
// Standalone interface, no dependencies.
interface impe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

### hdl/impe_out_if.sv
// Output channel of the extractor: one result item per transaction.
// Standalone interface, no dependencies.
interface impe_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] item_kind;
    logic [7:0] payload_byte;
    logic       run_last;

    modport source (output valid, output item_kind, output payload_byte, output run_last,
                    input ready);
    modport sink   (input valid, input item_kind, input payload_byte, input run_last,
                    output ready);
endinterface

### hdl/image_marker_payload_extractor.sv
// Top level of the image marker payload extractor: front end, command queue, back end.
// Depends on impe_pkg, impe_in_if, impe_out_if, impe_front, impe_queue and impe_back.
//
// The block takes one frame byte per transaction, looks for the first JPEG (FF D8 FF)
// or PNG (89 50 4E 47) marker and hands out the payload from the marker on, one
// byte per result transaction, closing each frame with a status item (done, too
// small, no marker) that carries run_last. Four bytes ahead of the marker, when
// present and nonzero, are a little-endian payload length. Input runs at one byte
// per cycle: every accepted byte becomes one command in a 4-entry queue, and the
// back end retires one result per cycle from its output buffer while the output
// is ready. Input falls behind only where one byte causes more than one result:
// the last byte of a frame adds its status item, and the first payload release of
// a frame brings up to MIN_FRAME_BYTES held bytes (plus status) out of one input
// byte; these are replayed from a byte ring memory at one per cycle, and the input
// stalls once the queue fills behind them. No clearing pass after reset is needed.
module image_marker_payload_extractor #(
    parameter int MIN_FRAME_BYTES = impe_pkg::MIN_FRAME_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    impe_in_if.sink    i_in_chan,
    impe_out_if.source o_out_chan
);
    localparam int DEPTH = impe_pkg::depth_of(MIN_FRAME_BYTES);
    localparam int CW    = impe_pkg::CNT_W;

    // front end -> queue
    logic           w_push_valid;
    logic           w_push_ready;
    impe_pkg::t_cmd w_q_cmd;

    // queue -> back end
    logic           w_pop_valid;
    logic           w_pop_ready;
    impe_pkg::t_cmd w_b_cmd;

    // marker search and payload accounting, one command per input transaction
    impe_front #(
        .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in_chan),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_cmd        (w_q_cmd)
    );

    // lets the front keep taking bytes while a payload burst drains
    impe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_cmd        (w_q_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_cmd        (w_b_cmd)
    );

    // ring memory replay and result buffering
    impe_back #(
        .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_cmd       (w_b_cmd),
        .o_out       (o_out_chan)
    );

    // back end only takes a command that is there
    a_pop_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop_ready |-> w_pop_valid)
        else $error("back end popped an empty command queue");

    // status items always close the run of results of their input byte
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_chan.valid && (o_out_chan.item_kind != impe_pkg::KIND_PAYLOAD))
        |-> o_out_chan.run_last)
        else $error("status item without run_last");

    // a short frame never releases payload
    a_small_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_valid && w_push_ready && w_q_cmd.has_status &&
         (w_q_cmd.kind == impe_pkg::KIND_SMALL)) |-> (w_q_cmd.count == '0))
        else $error("payload released in a frame that ended too small");

    // replay range stays inside the bytes held by the ring
    a_replay_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_valid && w_push_ready) |->
        ((w_q_cmd.count <= CW'(DEPTH)) && (w_q_cmd.back < CW'(DEPTH))))
        else $error("payload replay reaches beyond the delay depth");

endmodule

### hdl/impe_front.sv
// Front end: byte window, marker search, length decode and payload accounting.
// Depends on impe_pkg and impe_in_if; emits one t_cmd per accepted byte.
module impe_front #(
    parameter int MIN_FRAME_BYTES = impe_pkg::MIN_FRAME_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    impe_in_if.sink        i_in,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output impe_pkg::t_cmd o_cmd
);
    localparam int DEPTH = impe_pkg::depth_of(MIN_FRAME_BYTES);
    localparam int SW    = $clog2(DEPTH + 1);
    localparam int CW    = impe_pkg::CNT_W;
    localparam int WIN   = impe_pkg::WIN_TOP;
    localparam int STAP  = impe_pkg::SCAN_TAP;
    localparam int JLEN  = impe_pkg::JPEG_LEN;
    localparam int LB    = impe_pkg::LEN_BYTES;
    localparam int TK_W  = $clog2(STAP + 1);
    localparam logic [SW-1:0] DEPTH_C = SW'(DEPTH);
    localparam logic [SW-1:0] MIN_C   = SW'(MIN_FRAME_BYTES);
    localparam logic [SW-1:0] SCAN_C  = SW'(STAP + 1);

    // r_win[i] is the byte i+1 places behind the incoming one
    logic [7:0]    r_win [0:WIN-1];
    logic [SW-1:0] r_seen;
    logic          r_found;
    logic [31:0]   r_left;
    logic          r_unb;
    logic [SW-1:0] r_bss;

    logic [SW-1:0] n_seen;
    logic          n_found;
    logic [31:0]   n_left;
    logic          n_unb;
    logic [SW-1:0] n_bss;

    logic            w_accept;
    logic [SW-1:0]   w_seen_inc;
    logic            w_take;
    logic [TK_W-1:0] w_take_k;
    logic [31:0]     w_len;
    logic            w_len_room;
    logic            w_len_ok;
    logic            w_found;
    logic            w_unb;
    logic [31:0]     w_left;
    logic [SW-1:0]   w_bss;
    logic [SW-1:0]   w_cnt;
    logic [SW-1:0]   w_back;

    function automatic logic is_jpeg(input logic [7:0] b2, input logic [7:0] b1,
                                     input logic [7:0] b0);
        return (b2 == impe_pkg::JPEG_B0) && (b1 == impe_pkg::JPEG_B1) &&
               (b0 == impe_pkg::JPEG_B0);
    endfunction

    function automatic logic is_png(input logic [7:0] b3, input logic [7:0] b2,
                                    input logic [7:0] b1, input logic [7:0] b0);
        return (b3 == impe_pkg::PNG_B0) && (b2 == impe_pkg::PNG_B1) &&
               (b1 == impe_pkg::PNG_B2) && (b0 == impe_pkg::PNG_B3);
    endfunction

    assign w_accept     = i_in.valid && i_push_ready;
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;

    always_comb begin
        w_seen_inc = (r_seen < DEPTH_C) ? r_seen + 1'b1 : r_seen;

        // running scan at the fixed tap
        w_take   = 1'b0;
        w_take_k = TK_W'(STAP);
        if (!r_found && (w_seen_inc >= SCAN_C) &&
            (is_jpeg(r_win[STAP-1], r_win[STAP-2], r_win[STAP-3]) ||
             is_png(r_win[STAP-1], r_win[STAP-2], r_win[STAP-3], r_win[STAP-4]))) begin
            w_take = 1'b1;
        end

        // at frame end, JPEG markers closer to the tail that the scan never reached
        if (i_in.frame_end && !r_found && !w_take && (w_seen_inc >= MIN_C)) begin
            for (int k = STAP - 1; k >= JLEN; k--) begin
                if (!w_take && is_jpeg(r_win[k-1], r_win[k-2], r_win[k-3])) begin
                    w_take   = 1'b1;
                    w_take_k = TK_W'(k);
                end
            end
        end

        // little-endian length in the four bytes ahead of the marker
        w_len      = '0;
        w_len_room = 1'b0;
        for (int k = JLEN; k <= STAP; k++) begin
            if (w_take_k == TK_W'(k)) begin
                w_len      = {r_win[k], r_win[k+1], r_win[k+2], r_win[k+3]};
                w_len_room = (w_seen_inc >= SW'(k + LB + 1));
            end
        end
        w_len_ok = w_len_room && (w_len != '0);

        w_found = r_found || w_take;
        if (w_take) begin
            w_bss  = SW'(w_take_k) + 1'b1;
            w_unb  = !w_len_ok;
            w_left = w_len_ok ? w_len : '0;
        end else begin
            w_bss  = (r_found && (r_bss < DEPTH_C)) ? r_bss + 1'b1 : r_bss;
            w_unb  = r_unb;
            w_left = r_left;
        end

        // release held bytes once the frame is long enough
        w_cnt  = '0;
        w_back = '0;
        n_bss  = w_bss;
        n_left = w_left;
        if (w_found && (w_seen_inc >= MIN_C)) begin
            if (w_unb || (w_left >= 32'(w_bss))) begin
                w_cnt = w_bss;
            end else begin
                w_cnt = w_left[SW-1:0];
            end
            w_back = w_bss - 1'b1;
            n_left = w_unb ? w_left : w_left - 32'(w_cnt);
            n_bss  = '0;
        end

        o_cmd.data       = i_in.data_byte;
        o_cmd.count      = CW'(w_cnt);
        o_cmd.back       = CW'(w_back);
        o_cmd.has_status = i_in.frame_end;
        if (w_seen_inc < MIN_C) begin
            o_cmd.kind = impe_pkg::KIND_SMALL;
        end else if (!w_found) begin
            o_cmd.kind = impe_pkg::KIND_NOMARK;
        end else begin
            o_cmd.kind = impe_pkg::KIND_DONE;
        end

        if (i_in.frame_end) begin
            n_seen  = '0;
            n_found = 1'b0;
            n_left  = '0;
            n_unb   = 1'b0;
            n_bss   = '0;
        end else begin
            n_seen  = w_seen_inc;
            n_found = w_found;
            n_unb   = w_unb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_found <= 1'b0;
            r_left  <= '0;
            r_unb   <= 1'b0;
            r_bss   <= '0;
        end else if (w_accept) begin
            r_seen  <= n_seen;
            r_found <= n_found;
            r_left  <= n_left;
            r_unb   <= n_unb;
            r_bss   <= n_bss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_win[0] <= i_in.data_byte;
            for (int i = 1; i < WIN; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end
    end

endmodule

### hdl/impe_queue.sv
// Small command queue that decouples the front end from the result sequencer.
// Depends on impe_pkg for t_cmd and the queue depth.
module impe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  impe_pkg::t_cmd i_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output impe_pkg::t_cmd o_cmd
);
    localparam int QD = impe_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(QD);

    impe_pkg::t_cmd r_mem [0:QD-1];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [PW:0]    r_cnt;

    logic w_push;
    logic w_pop;

    assign o_push_ready = (r_cnt != (PW+1)'(QD));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_cmd        = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop_ready && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### hdl/impe_back.sv
// Back end: byte ring memory, result sequencer and two-slot output buffer.
// Depends on impe_pkg and impe_out_if; consumes t_cmd entries from impe_queue.
module impe_back #(
    parameter int MIN_FRAME_BYTES = impe_pkg::MIN_FRAME_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    output logic           o_pop_ready,
    input  impe_pkg::t_cmd i_cmd,
    impe_out_if.source     o_out
);
    localparam int DEPTH = impe_pkg::depth_of(MIN_FRAME_BYTES);
    localparam int AW    = $clog2(DEPTH);
    localparam int RING  = 1 << AW;
    localparam int CW    = impe_pkg::CNT_W;

    typedef struct packed {
        impe_pkg::t_kind kind;
        logic [7:0]      data;
        logic            last;
    } t_result;

    // ring of recent frame bytes, one write and one read a cycle
    logic [7:0]      r_ring [0:RING-1];
    logic [7:0]      r_rdata;
    logic [AW-1:0]   r_wp;

    // current command still being played out
    logic [CW-1:0]   r_rem;
    logic [AW-1:0]   r_raddr;
    logic            r_st_pend;
    impe_pkg::t_kind r_st_kind;

    // read stage
    logic            r_s_valid;
    logic            r_s_mem;
    impe_pkg::t_kind r_s_kind;
    logic            r_s_last;

    // output buffer, slot 0 is the head
    t_result         r_ob [0:1];
    logic [1:0]      r_ob_cnt;

    logic [CW-1:0]   n_rem;
    logic [AW-1:0]   n_raddr;
    logic            n_st_pend;
    impe_pkg::t_kind n_st_kind;

    logic            w_out_pop;
    logic [2:0]      w_level;
    logic            w_credit;
    logic            w_issue;
    logic            w_is_mem;
    impe_pkg::t_kind w_kind;
    logic            w_last;
    logic [AW-1:0]   w_rd_addr;
    logic            w_pop;
    logic [AW-1:0]   w_start;
    logic [1:0]      w_ob_idx;
    t_result         w_item;

    assign w_out_pop = (r_ob_cnt != 2'd0) && o_out.ready;
    assign w_level   = 3'(r_ob_cnt) + 3'(r_s_valid) - 3'(w_out_pop);
    assign w_credit  = (w_level <= 3'd1);
    assign w_start   = r_wp - i_cmd.back[AW-1:0];

    always_comb begin
        w_issue   = 1'b0;
        w_is_mem  = 1'b0;
        w_kind    = impe_pkg::KIND_PAYLOAD;
        w_last    = 1'b0;
        w_rd_addr = r_raddr;
        w_pop     = 1'b0;
        n_rem     = r_rem;
        n_raddr   = r_raddr;
        n_st_pend = r_st_pend;
        n_st_kind = r_st_kind;
        if (w_credit) begin
            if (r_rem != '0) begin
                w_issue  = 1'b1;
                w_is_mem = 1'b1;
                n_raddr  = r_raddr + 1'b1;
                n_rem    = r_rem - 1'b1;
                w_last   = (r_rem == CW'(1)) && !r_st_pend;
            end else if (r_st_pend) begin
                w_issue   = 1'b1;
                w_kind    = r_st_kind;
                w_last    = 1'b1;
                n_st_pend = 1'b0;
            end else if (i_pop_valid) begin
                w_pop = 1'b1;
                if (i_cmd.count != '0) begin
                    w_issue   = 1'b1;
                    w_is_mem  = 1'b1;
                    w_rd_addr = w_start;
                    n_raddr   = w_start + 1'b1;
                    n_rem     = i_cmd.count - 1'b1;
                    n_st_pend = i_cmd.has_status;
                    n_st_kind = i_cmd.kind;
                    w_last    = (i_cmd.count == CW'(1)) && !i_cmd.has_status;
                end else if (i_cmd.has_status) begin
                    w_issue = 1'b1;
                    w_kind  = i_cmd.kind;
                    w_last  = 1'b1;
                end
            end
        end
    end

    assign o_pop_ready = w_pop;

    // ring write and registered read; a read of the byte written this cycle forwards it
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_ring[r_wp] <= i_cmd.data;
        end
        if (w_issue && w_is_mem) begin
            r_rdata <= (w_pop && (w_rd_addr == r_wp)) ? i_cmd.data : r_ring[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rem     <= '0;
            r_raddr   <= '0;
            r_st_pend <= 1'b0;
            r_st_kind <= impe_pkg::KIND_PAYLOAD;
            r_s_valid <= 1'b0;
            r_ob_cnt  <= 2'd0;
        end else begin
            if (w_pop) begin
                r_wp <= r_wp + 1'b1;
            end
            r_rem     <= n_rem;
            r_raddr   <= n_raddr;
            r_st_pend <= n_st_pend;
            r_st_kind <= n_st_kind;
            r_s_valid <= w_issue;
            r_ob_cnt  <= r_ob_cnt - 2'(w_out_pop) + 2'(r_s_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s_mem  <= w_is_mem;
            r_s_kind <= w_kind;
            r_s_last <= w_last;
        end
    end

    assign w_ob_idx    = r_ob_cnt - 2'(w_out_pop);
    assign w_item.kind = r_s_mem ? impe_pkg::KIND_PAYLOAD : r_s_kind;
    assign w_item.data = r_s_mem ? r_rdata : 8'h00;
    assign w_item.last = r_s_last;

    // head slot takes the new item when it lands there, else shifts up on a pop
    always_ff @(posedge i_clk) begin
        if (r_s_valid && (w_ob_idx == 2'd0)) begin
            r_ob[0] <= w_item;
        end else if (w_out_pop) begin
            r_ob[0] <= r_ob[1];
        end
        if (r_s_valid && (w_ob_idx == 2'd1)) begin
            r_ob[1] <= w_item;
        end
    end

    assign o_out.valid        = (r_ob_cnt != 2'd0);
    assign o_out.item_kind    = r_ob[0].kind;
    assign o_out.payload_byte = r_ob[0].data;
    assign o_out.run_last     = r_ob[0].last;

endmodule
